FILE: sv/lzt_pkg.sv
// Package for the LZ78 nibble trie dictionary.
// Holds default sizes, stream widths, command codes and controller/datapath structs.
// No dependencies.
package lzt_pkg;

  localparam int NODES_DEF   = 4096;
  localparam int SYMBOLS_DEF = 16;

  localparam int NODE_W      = 12;
  localparam int SYMBOL_W    = 4;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 32;
  localparam int OUT_USED_W  = 1 + NODE_W + NODE_W + SYMBOL_W + 1;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_USED_W;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_FIND   = 1'b1;

  typedef struct packed {
    logic clear_wr;
    logic load;
    logic exec;
  } lzt_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic last_item;
    logic out_free;
  } lzt_sts_t;

endpackage

FILE: sv/lzt_ctrl.sv
// Controller for the LZ78 nibble trie dictionary.
// Sequences the child table clear pass and the accept / update steps per symbol.
// Depends on lzt_pkg.
module lzt_ctrl
  import lzt_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     s_tvalid_i,
  output logic     s_tready_o,
  input  lzt_sts_t sts_i,
  output lzt_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } state_e;

  state_e state_q;
  logic   ready_q;

  assign s_tready_o     = ready_q;
  assign cmd_o.clear_wr = (state_q == ST_CLEAR);
  assign cmd_o.load     = ready_q & s_tvalid_i;
  assign cmd_o.exec     = (state_q == ST_LOOKUP) & (~sts_i.last_item | sts_i.out_free);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      ready_q <= 1'b0;
    end else begin
      case (state_q)
        ST_CLEAR: begin
          if (sts_i.clear_last) begin
            state_q <= ST_IDLE;
            ready_q <= 1'b1;
          end
        end
        ST_IDLE: begin
          if (cmd_o.load) begin
            state_q <= ST_LOOKUP;
            ready_q <= 1'b0;
          end
        end
        ST_LOOKUP: begin
          if (cmd_o.exec) begin
            state_q <= ST_IDLE;
            ready_q <= 1'b1;
          end
        end
        default: begin
          state_q <= ST_CLEAR;
          ready_q <= 1'b0;
        end
      endcase
    end
  end

endmodule

FILE: sv/lzt_datapath.sv
// Datapath for the LZ78 nibble trie dictionary.
// Holds the child table memory, the walk state of the current word and the result register.
// Depends on lzt_pkg.
module lzt_datapath
  import lzt_pkg::*;
#(
  parameter int NODES   = NODES_DEF,
  parameter int SYMBOLS = SYMBOLS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  lzt_cmd_t               cmd_i,
  output lzt_sts_t               sts_o,
  input  logic                   in_cmd_i,
  input  logic [SYMBOL_W-1:0]    in_symbol_i,
  input  logic                   in_last_i,
  output logic                   m_tvalid_o,
  input  logic                   m_tready_i,
  output logic [OUT_TDATA_W-1:0] m_tdata_o
);

  localparam int IDX_W  = $clog2(NODES);
  localparam int SYM_W  = $clog2(SYMBOLS);
  localparam int ADDR_W = IDX_W + SYM_W;
  localparam int DEPTH  = NODES * (2 ** SYM_W);
  localparam int NF_W   = IDX_W + 1;
  localparam logic [NF_W-1:0]   NODES_C = NF_W'(NODES);
  localparam logic [ADDR_W-1:0] LAST_A  = ADDR_W'(DEPTH - 1);

  logic [IDX_W-1:0] mem [DEPTH];
  logic [IDX_W-1:0] rdata_q;
  logic             cmd_q;
  logic [SYM_W-1:0] sym_q;
  logic             last_q;

  logic [ADDR_W-1:0] clr_cnt_q;
  logic [NF_W-1:0]   nf_q, nf_d;
  logic [IDX_W-1:0]  cursor_q, cursor_d;
  logic [IDX_W-1:0]  cpar_q, cpar_d;
  logic [SYM_W-1:0]  csym_q, csym_d;
  logic              missed_q, missed_d;
  logic              created_q, created_d;
  logic [IDX_W-1:0]  lnode_q, lnode_d;
  logic [IDX_W-1:0]  lpar_q, lpar_d;
  logic [SYM_W-1:0]  lsym_q, lsym_d;
  logic              full_q, full_d;
  logic              create;

  logic              hit;
  logic [IDX_W-1:0]  res_node;
  logic [IDX_W-1:0]  res_par;
  logic [SYM_W-1:0]  res_sym;
  logic              res_full;

  logic                   m_valid_q;
  logic [OUT_TDATA_W-1:0] m_data_q;

  logic [SYM_W-1:0]  sym_red;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [IDX_W-1:0]  wdata;

  function automatic logic [SYM_W-1:0] sym_reduce(logic [SYMBOL_W-1:0] s);
    logic [SYM_W-1:0] r;
    r = '0;
    for (int v = 0; v < 2 ** SYMBOL_W; v++) begin
      if (s == SYMBOL_W'(v)) begin
        r = SYM_W'(v % SYMBOLS);
      end
    end
    return r;
  endfunction

  assign sym_red = sym_reduce(in_symbol_i);

  assign we    = cmd_i.clear_wr | (cmd_i.exec & create);
  assign waddr = cmd_i.clear_wr ? clr_cnt_q : {cursor_q, sym_q};
  assign wdata = cmd_i.clear_wr ? '0 : nf_q[IDX_W-1:0];

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (cmd_i.load) begin
      rdata_q <= mem[{cursor_q, sym_red}];
      cmd_q   <= in_cmd_i;
      sym_q   <= sym_red;
      last_q  <= in_last_i;
    end
  end

  always_comb begin
    nf_d      = nf_q;
    cursor_d  = cursor_q;
    cpar_d    = cpar_q;
    csym_d    = csym_q;
    missed_d  = missed_q;
    created_d = created_q;
    lnode_d   = lnode_q;
    lpar_d    = lpar_q;
    lsym_d    = lsym_q;
    full_d    = full_q;
    create    = 1'b0;
    if (!missed_q) begin
      if (rdata_q != '0) begin
        cursor_d = rdata_q;
        cpar_d   = cursor_q;
        csym_d   = sym_q;
      end else if (cmd_q == CMD_INSERT) begin
        if (nf_q < NODES_C) begin
          create    = 1'b1;
          cursor_d  = nf_q[IDX_W-1:0];
          cpar_d    = cursor_q;
          csym_d    = sym_q;
          lnode_d   = nf_q[IDX_W-1:0];
          lpar_d    = cursor_q;
          lsym_d    = sym_q;
          created_d = 1'b1;
          nf_d      = nf_q + NF_W'(1);
        end else begin
          full_d   = 1'b1;
          missed_d = 1'b1;
        end
      end else begin
        missed_d = 1'b1;
      end
    end
  end

  always_comb begin
    if (cmd_q == CMD_INSERT) begin
      hit      = created_d;
      res_node = lnode_d;
      res_par  = lpar_d;
      res_sym  = lsym_d;
      res_full = full_d;
    end else begin
      hit      = ~missed_d;
      res_node = cursor_d;
      res_par  = cpar_d;
      res_sym  = csym_d;
      res_full = 1'b0;
    end
    if (!hit) begin
      res_node = '0;
      res_par  = '0;
      res_sym  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
      nf_q      <= NF_W'(1);
      cursor_q  <= '0;
      cpar_q    <= '0;
      csym_q    <= '0;
      missed_q  <= 1'b0;
      created_q <= 1'b0;
      lnode_q   <= '0;
      lpar_q    <= '0;
      lsym_q    <= '0;
      full_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clear_wr) begin
        clr_cnt_q <= clr_cnt_q + ADDR_W'(1);
      end
      if (cmd_i.exec) begin
        nf_q <= nf_d;
        if (last_q) begin
          cursor_q  <= '0;
          cpar_q    <= '0;
          csym_q    <= '0;
          missed_q  <= 1'b0;
          created_q <= 1'b0;
          lnode_q   <= '0;
          lpar_q    <= '0;
          lsym_q    <= '0;
          full_q    <= 1'b0;
        end else begin
          cursor_q  <= cursor_d;
          cpar_q    <= cpar_d;
          csym_q    <= csym_d;
          missed_q  <= missed_d;
          created_q <= created_d;
          lnode_q   <= lnode_d;
          lpar_q    <= lpar_d;
          lsym_q    <= lsym_d;
          full_q    <= full_d;
        end
      end
      if (cmd_i.exec && last_q) begin
        m_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && last_q) begin
      m_data_q <= {{OUT_PAD_W{1'b0}}, res_full, SYMBOL_W'(res_sym), NODE_W'(res_par),
                   NODE_W'(res_node), hit};
    end
  end

  assign m_tvalid_o       = m_valid_q;
  assign m_tdata_o        = m_data_q;
  assign sts_o.clear_last = (clr_cnt_q == LAST_A);
  assign sts_o.last_item  = last_q;
  assign sts_o.out_free   = ~m_valid_q | m_tready_i;

endmodule

FILE: sv/lz78_nibble_trie_dictionary.sv
// Top level of the LZ78 nibble trie dictionary.
// Joins lzt_ctrl and lzt_datapath; depends on lzt_pkg.
//
// After reset the child table is swept to zero, one entry per cycle, over all
// NODES * 2**clog2(SYMBOLS) entries (65536 at the defaults); s_axis_tready stays
// low until the sweep ends. Each symbol is accepted first, with the child table
// read at {cursor, symbol}; an update step then follows or creates the child and
// writes the single-port child table. The item marked tlast leaves one result in
// an output register; if the previous result is still not taken, that item holds
// in its update cycle until the register frees.
module lz78_nibble_trie_dictionary
  import lzt_pkg::*;
#(
  parameter int NODES   = NODES_DEF,
  parameter int SYMBOLS = SYMBOLS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // cmd[0], symbol[4:1], zero[7:5]
  input  logic                   s_axis_tlast,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata   // hit[0], node_index[12:1],
                                                // parent_index[24:13], node_symbol[28:25],
                                                // table_full[29], zero[31:30]
);

  lzt_cmd_t cmd;
  lzt_sts_t sts;

  lzt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lzt_datapath #(
    .NODES   (NODES),
    .SYMBOLS (SYMBOLS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_cmd_i    (s_axis_tdata[0]),
    .in_symbol_i (s_axis_tdata[SYMBOL_W:1]),
    .in_last_i   (s_axis_tlast),
    .m_tvalid_o  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_o   (m_axis_tdata)
  );

endmodule

FILE: sv/lzt_checker.sv
// Port checker for the LZ78 nibble trie dictionary, bound to the top level.
// Watches the stream ports only; depends on lzt_pkg.
module lzt_checker
  import lzt_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic                   s_axis_tlast,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  logic s_xfer;

  assign s_xfer = s_axis_tvalid & s_axis_tready;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[28:1] == '0)
    else $error("node fields not zero on a miss");

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_xfer |=> !s_axis_tready)
    else $error("second transaction taken during update");

  a_result_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_xfer && s_axis_tlast, 2))
    else $error("result without a final symbol transaction");

endmodule

bind lz78_nibble_trie_dictionary lzt_checker u_lzt_checker (.*);
